// ===== rtl/fetch_block_former_predecode_macros.svh =====
// Assertion macros for the fetch block former with predecode.
// Depends on nothing; the including module supplies the clock and reset names.
`ifndef FETCH_BLOCK_FORMER_PREDECODE_MACROS_SVH
`define FETCH_BLOCK_FORMER_PREDECODE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FBPD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fetch block former: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FBPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fetch block former: next-cycle check failed");

`endif

// ===== rtl/fbpd_pkg.sv =====
// Shared types and constants of the fetch block former with predecode.
// Used by fbpd_predecode, fbpd_former and fetch_block_former_predecode.
package fbpd_pkg;

   // Field widths of the transfer payloads.
   localparam int unsigned PC_W    = 64;
   localparam int unsigned INST_W  = 32;
   localparam int unsigned IDX_W   = 16;
   localparam int unsigned BYTES_W = 7;
   localparam int unsigned COUNT_W = 5;

   // Saturation points of the block byte and instruction counts.
   localparam logic [BYTES_W-1:0] BYTES_MAX = 7'd127;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // Reset value of the overflow limit register.
   localparam logic [BYTES_W-1:0] LIMIT_RESET = 7'd32;

   // Instruction sizes in bytes.
   localparam logic [2:0] SIZE_RVC = 3'd2;
   localparam logic [2:0] SIZE_STD = 3'd4;

   // Opcode quadrants and major opcodes.
   localparam logic [1:0] QUAD_C1  = 2'b01;
   localparam logic [1:0] QUAD_C2  = 2'b10;
   localparam logic [1:0] QUAD_STD = 2'b11;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;

   // Function codes.
   localparam logic [2:0] F3_C_J     = 3'b101;
   localparam logic [2:0] F3_C_BEQZ  = 3'b110;
   localparam logic [2:0] F3_C_BNEZ  = 3'b111;
   localparam logic [2:0] F3_C_JR    = 3'b100;
   localparam logic [2:0] F3_JALR    = 3'b000;
   localparam logic [4:0] REG_ZERO   = 5'b00000;

   // Link registers.
   localparam logic [4:0] REG_RA = 5'd1;
   localparam logic [4:0] REG_T0 = 5'd5;

   // Control-flow class of an instruction.
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_BRANCH = 2'd1,
      KIND_JAL    = 2'd2,
      KIND_JALR   = 2'd3
   } kind_type;

   // Predecode outcome of one instruction word.
   typedef struct packed {
      logic     is_compressed;
      kind_type kind;
      logic     is_call;
      logic     is_return;
   } predecode_type;

   // One result item.
   typedef struct packed {
      logic [IDX_W-1:0]   inst_index;
      logic [IDX_W-1:0]   block_index;
      logic [PC_W-1:0]    next_fetch_pc;
      logic               jump_or_taken;
      logic               last_in_block;
      kind_type           branch_kind;
      logic               is_call;
      logic               is_return;
      logic               is_compressed;
      logic [IDX_W-1:0]   block_first_index;
      logic [COUNT_W-1:0] block_count;
      logic               overflow_error;
   } result_type;

   // A word is compressed unless its low two bits are both set.
   function automatic logic is_rvc(input logic [1:0] low_bits);
      return low_bits != QUAD_STD;
   endfunction

   // Link register test used for call and return hints.
   function automatic logic is_link(input logic [4:0] reg_num);
      return (reg_num == REG_RA) || (reg_num == REG_T0);
   endfunction

endpackage

// ===== rtl/fetch_block_former_predecode.sv =====
// Fetch block former with RISC-V predecode. Each transfer on the req_ side carries one
// committed instruction with the pc and word of the instruction after it; each yields one
// transfer on the rsp_ side with predecode hints, the next fetch pc and block bookkeeping.
// The block takes one instruction per cycle while rsp_stall is low, because the block byte
// count and index counters update with each item that moves on. A result passes through the
// input register and then the result register before it is presented; a stall holds it there.
// A stalled result holds the next item in the input register, which then stalls the req_ side.
// csr_wr_data sets the byte limit above which overflow_error is raised (32 after reset);
// write it only while idle.
// Depends on fbpd_pkg, fbpd_predecode, fbpd_former and fetch_block_former_predecode_macros.svh.
`include "fetch_block_former_predecode_macros.svh"

module fetch_block_former_predecode #(
   parameter int unsigned INDEX_BITS        = 16,
   parameter int unsigned FETCH_BLOCK_BYTES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fbpd_pkg::PC_W-1:0]     req_pc,
   input  logic [fbpd_pkg::INST_W-1:0]   req_inst,
   input  logic [fbpd_pkg::PC_W-1:0]     req_next_pc,
   input  logic [fbpd_pkg::INST_W-1:0]   req_next_inst,
   input  logic                          req_next_valid,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fbpd_pkg::IDX_W-1:0]    rsp_inst_index,
   output logic [fbpd_pkg::IDX_W-1:0]    rsp_block_index,
   output logic [fbpd_pkg::PC_W-1:0]     rsp_next_fetch_pc,
   output logic                          rsp_jump_or_taken,
   output logic                          rsp_last_in_block,
   output logic [1:0]                    rsp_branch_kind,
   output logic                          rsp_is_call,
   output logic                          rsp_is_return,
   output logic                          rsp_is_compressed,
   output logic [fbpd_pkg::IDX_W-1:0]    rsp_block_first_index,
   output logic [fbpd_pkg::COUNT_W-1:0]  rsp_block_count,
   output logic                          rsp_overflow_error,
   // Configuration port.
   input  logic                          csr_wr_en,
   input  logic [fbpd_pkg::BYTES_W-1:0]  csr_wr_data
);

   logic                          in_valid_ff, in_valid_in;
   logic [fbpd_pkg::PC_W-1:0]     in_pc_ff;
   logic [fbpd_pkg::INST_W-1:0]   in_inst_ff;
   logic [fbpd_pkg::PC_W-1:0]     in_next_pc_ff;
   logic [fbpd_pkg::INST_W-1:0]   in_next_inst_ff;
   logic                          in_next_valid_ff;
   logic                          out_valid_ff, out_valid_in;
   fbpd_pkg::result_type          result_ff;
   fbpd_pkg::result_type          result;
   fbpd_pkg::predecode_type       decode;
   logic [fbpd_pkg::BYTES_W-1:0]  limit_ff;
   logic                          advance;
   logic                          in_take;

   // Handshake: the held item moves on whenever the result register is free or drains.
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_take     = req_valid && !req_stall;
   assign in_valid_in = in_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Valid flags and overflow limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= fbpd_pkg::LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Input payload register, loaded on each input transfer.
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_pc_ff         <= req_pc;
         in_inst_ff       <= req_inst;
         in_next_pc_ff    <= req_next_pc;
         in_next_inst_ff  <= req_next_inst;
         in_next_valid_ff <= req_next_valid;
      end
   end

   fbpd_predecode u_predecode (
      .inst   (in_inst_ff),
      .decode (decode)
   );

   fbpd_former #(
      .INDEX_BITS        (INDEX_BITS),
      .FETCH_BLOCK_BYTES (FETCH_BLOCK_BYTES)
   ) u_former (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pc         (in_pc_ff),
      .next_pc    (in_next_pc_ff),
      .next_inst  (in_next_inst_ff),
      .next_valid (in_next_valid_ff),
      .limit      (limit_ff),
      .decode     (decode),
      .result     (result)
   );

   // Result register, loaded when the held item moves on.
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_inst_index        = result_ff.inst_index;
   assign rsp_block_index       = result_ff.block_index;
   assign rsp_next_fetch_pc     = result_ff.next_fetch_pc;
   assign rsp_jump_or_taken     = result_ff.jump_or_taken;
   assign rsp_last_in_block     = result_ff.last_in_block;
   assign rsp_branch_kind       = 2'(result_ff.branch_kind);
   assign rsp_is_call           = result_ff.is_call;
   assign rsp_is_return         = result_ff.is_return;
   assign rsp_is_compressed     = result_ff.is_compressed;
   assign rsp_block_first_index = result_ff.block_first_index;
   assign rsp_block_count       = result_ff.block_count;
   assign rsp_overflow_error    = result_ff.overflow_error;

   // The input side only stalls while an item is held.
   `FBPD_ASSERT_NOW(a_stall_needs_item, req_stall, in_valid_ff)
   // A jump or taken branch always closes its block.
   `FBPD_ASSERT_NOW(a_jot_closes_block, rsp_valid && rsp_jump_or_taken, rsp_last_in_block)
   // The first instruction of a block carries the block's start index.
   `FBPD_ASSERT_NOW(a_first_index, rsp_valid && (rsp_block_count == 5'd1),
                    rsp_block_first_index == rsp_inst_index)
   // A moving item always shows up as a result in the next cycle.
   `FBPD_ASSERT_NEXT(a_advance_shows, advance, rsp_valid)

endmodule

// ===== rtl/fbpd_predecode.sv =====
// Predecoder: classifies one instruction word as compressed or not, its
// control-flow kind, and call or return. Depends on fbpd_pkg.
module fbpd_predecode (
   input  logic [fbpd_pkg::INST_W-1:0] inst,
   output fbpd_pkg::predecode_type     decode
);

   logic                 rvc;
   fbpd_pkg::kind_type   kind;
   logic [4:0]           rd;
   logic [4:0]           rs1;
   logic                 call;

   assign rvc = fbpd_pkg::is_rvc(inst[1:0]);

   // Control-flow kind from the quadrant and function code.
   always_comb begin
      kind = fbpd_pkg::KIND_NONE;
      if (rvc) begin
         case (inst[1:0])
            fbpd_pkg::QUAD_C1: begin
               if (inst[15:13] == fbpd_pkg::F3_C_J) begin
                  kind = fbpd_pkg::KIND_JAL;
               end else if (inst[15:13] == fbpd_pkg::F3_C_BEQZ ||
                            inst[15:13] == fbpd_pkg::F3_C_BNEZ) begin
                  kind = fbpd_pkg::KIND_BRANCH;
               end
            end
            fbpd_pkg::QUAD_C2: begin
               // c.jr and c.jalr only; c.ebreak and the rs1 = x0 form are not jumps.
               if (inst[15:13] == fbpd_pkg::F3_C_JR && inst[6:2] == fbpd_pkg::REG_ZERO &&
                   inst[11:7] != fbpd_pkg::REG_ZERO) begin
                  kind = fbpd_pkg::KIND_JALR;
               end
            end
            default: kind = fbpd_pkg::KIND_NONE;
         endcase
      end else begin
         case (inst[6:0])
            fbpd_pkg::OPC_BRANCH: kind = fbpd_pkg::KIND_BRANCH;
            fbpd_pkg::OPC_JAL:    kind = fbpd_pkg::KIND_JAL;
            fbpd_pkg::OPC_JALR: begin
               if (inst[14:12] == fbpd_pkg::F3_JALR) begin
                  kind = fbpd_pkg::KIND_JALR;
               end
            end
            default: kind = fbpd_pkg::KIND_NONE;
         endcase
      end
   end

   // Link and source registers; a compressed jalr links to x1 when bit 12 is set.
   always_comb begin
      if (rvc) begin
         rd  = {4'b0000, inst[12]};
         rs1 = (kind == fbpd_pkg::KIND_JAL) ? fbpd_pkg::REG_ZERO : inst[11:7];
      end else begin
         rd  = inst[11:7];
         rs1 = inst[19:15];
      end
   end

   // A compressed jal is never a call.
   assign call = (((kind == fbpd_pkg::KIND_JAL) && !rvc) || (kind == fbpd_pkg::KIND_JALR)) &&
                 fbpd_pkg::is_link(rd);

   assign decode.is_compressed = rvc;
   assign decode.kind          = kind;
   assign decode.is_call       = call;
   assign decode.is_return     = (kind == fbpd_pkg::KIND_JALR) && fbpd_pkg::is_link(rs1) && !call;

endmodule

// ===== rtl/fbpd_former.sv =====
// Fetch block former: block byte and instruction counts, index counters and
// the block-closing decision for one predecoded instruction. Depends on fbpd_pkg.
module fbpd_former #(
   parameter int unsigned INDEX_BITS        = 16,
   parameter int unsigned FETCH_BLOCK_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [fbpd_pkg::PC_W-1:0]           pc,
   input  logic [fbpd_pkg::PC_W-1:0]           next_pc,
   input  logic [fbpd_pkg::INST_W-1:0]         next_inst,
   input  logic                                next_valid,
   input  logic [fbpd_pkg::BYTES_W-1:0]        limit,
   input  fbpd_pkg::predecode_type             decode,
   output fbpd_pkg::result_type                result
);

   // Only the low bits of an index ever reach the result ports.
   localparam int unsigned CntW = (INDEX_BITS < fbpd_pkg::IDX_W) ? INDEX_BITS : fbpd_pkg::IDX_W;

   logic [fbpd_pkg::BYTES_W-1:0] block_bytes_ff, block_bytes_in;
   logic [fbpd_pkg::COUNT_W-1:0] block_count_ff, block_count_in;
   logic [CntW-1:0]              block_start_ff, block_start_in;
   logic [CntW-1:0]              inst_counter_ff, inst_counter_in;
   logic [CntW-1:0]              block_counter_ff, block_counter_in;

   logic [2:0]                   size;
   logic [2:0]                   next_size;
   logic [fbpd_pkg::BYTES_W:0]   bytes_sum;
   logic [fbpd_pkg::BYTES_W-1:0] bytes;
   logic [fbpd_pkg::BYTES_W:0]   bytes_ahead;
   logic [fbpd_pkg::COUNT_W-1:0] count;
   logic [fbpd_pkg::PC_W-1:0]    npc;
   logic [fbpd_pkg::PC_W-1:0]    seq_pc;
   logic                         disc;
   logic                         jump;
   logic                         jot;
   logic                         last;

   // Sizes of this and the following instruction; a missing one counts as a zero word.
   assign size      = decode.is_compressed ? fbpd_pkg::SIZE_RVC : fbpd_pkg::SIZE_STD;
   assign next_size = (!next_valid || fbpd_pkg::is_rvc(next_inst[1:0])) ?
                      fbpd_pkg::SIZE_RVC : fbpd_pkg::SIZE_STD;
   assign npc       = next_valid ? next_pc : '0;

   // Saturating byte and instruction counts including this instruction.
   assign bytes_sum   = {1'b0, block_bytes_ff} + {5'b00000, size};
   assign bytes       = bytes_sum[fbpd_pkg::BYTES_W] ? fbpd_pkg::BYTES_MAX
                                                     : bytes_sum[fbpd_pkg::BYTES_W-1:0];
   assign count       = (block_count_ff == fbpd_pkg::COUNT_MAX) ? fbpd_pkg::COUNT_MAX
                                                                : block_count_ff + 5'd1;
   assign bytes_ahead = {1'b0, bytes} + {5'b00000, next_size};

   // Discontinuity and block-closing decision.
   assign seq_pc = pc + {{(fbpd_pkg::PC_W-3){1'b0}}, size};
   assign disc   = seq_pc != npc;
   assign jump   = (decode.kind == fbpd_pkg::KIND_JAL) || (decode.kind == fbpd_pkg::KIND_JALR);
   assign jot    = (disc && (decode.kind != fbpd_pkg::KIND_NONE)) || jump;
   assign last   = disc || jot ||
                   (bytes_ahead > (fbpd_pkg::BYTES_W+1)'(FETCH_BLOCK_BYTES));

   // Result fields.
   always_comb begin
      result.inst_index        = fbpd_pkg::IDX_W'(inst_counter_ff);
      result.block_index       = fbpd_pkg::IDX_W'(block_counter_ff);
      result.next_fetch_pc     = jot ? npc : seq_pc;
      result.jump_or_taken     = jot;
      result.last_in_block     = last;
      result.branch_kind       = decode.kind;
      result.is_call           = decode.is_call;
      result.is_return         = decode.is_return;
      result.is_compressed     = decode.is_compressed;
      result.block_first_index = fbpd_pkg::IDX_W'(block_start_ff);
      result.block_count       = count;
      result.overflow_error    = bytes > limit;
   end

   // Next state: a closing instruction starts a fresh block at the next index.
   always_comb begin
      inst_counter_in  = inst_counter_ff;
      block_counter_in = block_counter_ff;
      block_bytes_in   = block_bytes_ff;
      block_count_in   = block_count_ff;
      block_start_in   = block_start_ff;
      if (advance) begin
         inst_counter_in = inst_counter_ff + CntW'(1);
         if (last) begin
            block_counter_in = block_counter_ff + CntW'(1);
            block_bytes_in   = '0;
            block_count_in   = '0;
            block_start_in   = inst_counter_ff + CntW'(1);
         end else begin
            block_bytes_in = bytes;
            block_count_in = count;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inst_counter_ff  <= '0;
         block_counter_ff <= '0;
         block_bytes_ff   <= '0;
         block_count_ff   <= '0;
         block_start_ff   <= '0;
      end else begin
         inst_counter_ff  <= inst_counter_in;
         block_counter_ff <= block_counter_in;
         block_bytes_ff   <= block_bytes_in;
         block_count_ff   <= block_count_in;
         block_start_ff   <= block_start_in;
      end
   end

endmodule
